// ----- rtl/core/sva_pkg.sv -----
`default_nettype none
package sva_pkg;

    localparam int VOICES      = 16;
    localparam int STACK_DEPTH = 256;
    localparam int VW          = $clog2(VOICES);
    localparam int SW          = $clog2(STACK_DEPTH);
    localparam int KEY_W       = 11;
    localparam int ADDR_W      = 4;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_ALL_OFF  = 2'd2;
    localparam logic [1:0] OP_FINISHED = 2'd3;

    localparam logic [1:0] REG_MONO  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_DUAL  = 2'd2;

    localparam logic ACT_TRIG = 1'b0;
    localparam logic ACT_REL  = 1'b1;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] channel;
        logic [6:0] note;
        logic [3:0] voice;
    } t_in_item;

    typedef struct packed {
        logic [3:0] voice_index;
        logic       action;
        logic [3:0] key_channel;
        logic [6:0] key_note;
        logic       last;
    } t_out_item;

endpackage
`default_nettype wire

// ----- rtl/core/sva_stack.sv -----
`default_nettype none
module sva_stack (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [sva_pkg::SW-1:0]    i_waddr,
    input  wire sva_pkg::t_key             i_wdata,
    input  wire logic [sva_pkg::SW-1:0]    i_raddr,
    output sva_pkg::t_key                  o_rdata
);
    import sva_pkg::*;

    t_key r_mem [STACK_DEPTH];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/core/synth_voice_allocator.sv -----
`default_nettype none
// note on: mono pushes the held stack; poly scans, one voice per cycle
// note off: poly scans every voice; mono compacts the held stack, then retriggers its top
// all notes off: scans every voice; voice finished: handled on accept; one event at a time
// latency set by the shared voice compare unit and the stack memory; output stalls add cycles
// synchronous active-low reset clears voices, age counter, stack count and registers
module synth_voice_allocator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire sva_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output sva_pkg::t_out_item               o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sva_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import sva_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_HELD, S_FREE, S_OLD, S_REL, S_ALL, S_RD, S_CMP, S_TOP, S_FLUSH
    } t_state;

    t_state          r_state;
    logic            r_mono;
    logic [4:0]      r_limit;
    logic            r_dual;

    logic            r_sounding [VOICES];
    logic            r_held     [VOICES];
    t_key            r_vkey     [VOICES];
    logic [31:0]     r_age      [VOICES];
    logic [31:0]     r_age_ctr;
    logic [SW:0]     r_stack_cnt;

    t_key            r_key;
    logic [VW:0]     r_scan;
    logic [VW-1:0]   r_best;
    logic [31:0]     r_best_span;
    logic [SW:0]     r_rd;
    logic [SW:0]     r_wr;

    logic            r_pend_valid;
    logic [VW-1:0]   r_pend_v;
    logic            r_pend_act;
    t_key            r_pend_key;

    logic            r_out_valid;
    t_out_item       r_out;

    logic            w_accept;
    logic            w_can_push;
    logic [VW-1:0]   w_idx;
    logic            w_holds;
    logic            w_rel_hit;
    logic            w_push;
    logic [31:0]     w_span;
    logic [VW:0]     w_lim;
    logic [VW:0]     w_clamp;
    t_key            w_in_key;
    logic            w_we;
    logic [SW-1:0]   w_waddr;
    t_key            w_wdata;
    logic [SW-1:0]   w_raddr;
    t_key            w_rdata;
    logic [SW:0]     w_top;

    assign w_in_key   = {i_in_data.channel, i_in_data.note};
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_can_push = !r_out_valid || !i_out_stall;
    assign w_idx      = r_scan[VW-1:0];
    assign w_holds    = r_held[w_idx] && (r_vkey[w_idx] == r_key);
    assign w_rel_hit  = (r_state == S_REL) ? w_holds : r_sounding[w_idx];
    assign w_span     = r_age_ctr - r_age[w_idx];
    assign w_clamp    = (int'(r_limit) > VOICES) ? (VW+1)'(VOICES) : (VW+1)'(r_limit);
    assign w_lim      = r_dual ? (w_clamp >> 1) : w_clamp;
    assign w_top      = r_wr - 1'b1;

    always_comb begin
        w_push = 1'b0;
        if (r_state == S_FLUSH) begin
            w_push = r_pend_valid && w_can_push;
        end else if ((r_state == S_REL || r_state == S_ALL) && int'(r_scan) != VOICES
                     && w_rel_hit) begin
            w_push = r_pend_valid && w_can_push;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_stack_cnt[SW-1:0];
        w_wdata = w_in_key;
        if (r_state == S_CMP) begin
            w_we    = (w_rdata != r_key);
            w_waddr = r_wr[SW-1:0];
            w_wdata = w_rdata;
        end else if (w_accept && r_mono && i_in_data.opcode == OP_NOTE_ON) begin
            w_we = (int'(r_stack_cnt) < STACK_DEPTH);
        end
        w_raddr = (r_rd == r_stack_cnt) ? w_top[SW-1:0] : r_rd[SW-1:0];
    end

    sva_stack u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (paddr[3:2])
            REG_MONO:  prdata = {31'd0, r_mono};
            REG_LIMIT: prdata = {27'd0, r_limit};
            REG_DUAL:  prdata = {31'd0, r_dual};
            default:   prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mono       <= 1'b0;
            r_limit      <= 5'd16;
            r_dual       <= 1'b0;
            r_age_ctr    <= 32'd0;
            r_stack_cnt  <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                r_sounding[i] <= 1'b0;
                r_held[i]     <= 1'b0;
                r_vkey[i]     <= '0;
                r_age[i]      <= 32'd0;
            end
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    REG_MONO:  r_mono  <= pwdata[0];
                    REG_LIMIT: r_limit <= pwdata[4:0];
                    REG_DUAL:  r_dual  <= pwdata[0];
                    default:   ;
                endcase
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
                r_out <= '{voice_index: 4'(r_pend_v), action: r_pend_act,
                           key_channel: r_pend_key[10:7],
                           key_note: r_pend_key[6:0], last: (r_state == S_FLUSH)};
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_key  <= w_in_key;
                        r_scan <= '0;
                        r_rd   <= '0;
                        r_wr   <= '0;
                        unique case (i_in_data.opcode)
                            OP_NOTE_ON: begin
                                if (r_mono) begin
                                    if (int'(r_stack_cnt) < STACK_DEPTH) begin
                                        r_stack_cnt <= r_stack_cnt + 1'b1;
                                    end
                                    r_sounding[0] <= 1'b1;
                                    r_held[0]     <= 1'b1;
                                    r_vkey[0]     <= w_in_key;
                                    r_age[0]      <= r_age_ctr;
                                    r_age_ctr     <= r_age_ctr + 1'b1;
                                    r_pend_valid  <= 1'b1;
                                    r_pend_v      <= '0;
                                    r_pend_act    <= ACT_TRIG;
                                    r_pend_key    <= w_in_key;
                                    r_state       <= S_FLUSH;
                                end else begin
                                    r_state <= S_HELD;
                                end
                            end
                            OP_NOTE_OFF: r_state <= r_mono ? S_RD : S_REL;
                            OP_ALL_OFF:  r_state <= S_ALL;
                            OP_FINISHED: begin
                                if (int'(i_in_data.voice) < VOICES) begin
                                    r_sounding[VW'(i_in_data.voice)] <= 1'b0;
                                    r_held[VW'(i_in_data.voice)]     <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_HELD: begin
                    if (int'(r_scan) == VOICES) begin
                        r_scan  <= '0;
                        r_state <= S_FREE;
                    end else if (w_holds) begin
                        r_sounding[w_idx] <= 1'b1;
                        r_age[w_idx]      <= r_age_ctr;
                        r_age_ctr         <= r_age_ctr + 1'b1;
                        r_pend_valid      <= 1'b1;
                        r_pend_v          <= w_idx;
                        r_pend_act        <= ACT_TRIG;
                        r_pend_key        <= r_key;
                        r_state           <= S_FLUSH;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_FREE: begin
                    if (r_scan >= w_lim) begin
                        r_scan  <= '0;
                        r_best  <= '0;
                        r_state <= S_OLD;
                    end else if (!r_sounding[w_idx]) begin
                        r_best  <= w_idx;
                        r_scan  <= w_lim;
                        r_state <= S_OLD;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_OLD: begin
                    if (r_scan >= w_lim) begin
                        r_sounding[r_best] <= 1'b1;
                        r_held[r_best]     <= 1'b1;
                        r_vkey[r_best]     <= r_key;
                        r_age[r_best]      <= r_age_ctr;
                        r_age_ctr          <= r_age_ctr + 1'b1;
                        r_pend_valid       <= 1'b1;
                        r_pend_v           <= r_best;
                        r_pend_act         <= ACT_TRIG;
                        r_pend_key         <= r_key;
                        r_state            <= S_FLUSH;
                    end else begin
                        if (r_scan == '0 || w_span > r_best_span) begin
                            r_best      <= w_idx;
                            r_best_span <= w_span;
                        end
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_REL, S_ALL: begin
                    if (int'(r_scan) == VOICES) begin
                        if (r_state == S_ALL) begin
                            r_stack_cnt <= '0;
                        end
                        r_state <= S_FLUSH;
                    end else if (w_rel_hit) begin
                        if (!r_pend_valid || w_can_push) begin
                            r_held[w_idx] <= 1'b0;
                            r_pend_valid  <= 1'b1;
                            r_pend_v      <= w_idx;
                            r_pend_act    <= ACT_REL;
                            r_pend_key    <= r_vkey[w_idx];
                            r_scan        <= r_scan + 1'b1;
                        end
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_RD: begin
                    if (r_rd == r_stack_cnt) begin
                        r_stack_cnt <= r_wr;
                        if (r_held[0] && r_vkey[0] == r_key) begin
                            if (r_wr != '0) begin
                                r_state <= S_TOP;
                            end else begin
                                r_held[0]    <= 1'b0;
                                r_pend_valid <= 1'b1;
                                r_pend_v     <= '0;
                                r_pend_act   <= ACT_REL;
                                r_pend_key   <= r_vkey[0];
                                r_state      <= S_FLUSH;
                            end
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_rdata != r_key) begin
                        r_wr <= r_wr + 1'b1;
                    end
                    r_rd    <= r_rd + 1'b1;
                    r_state <= S_RD;
                end
                S_TOP: begin
                    r_sounding[0] <= 1'b1;
                    r_held[0]     <= 1'b1;
                    r_vkey[0]     <= w_rdata;
                    r_age[0]      <= r_age_ctr;
                    r_age_ctr     <= r_age_ctr + 1'b1;
                    r_pend_valid  <= 1'b1;
                    r_pend_v      <= '0;
                    r_pend_act    <= ACT_TRIG;
                    r_pend_key    <= w_rdata;
                    r_state       <= S_FLUSH;
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (w_can_push) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending command left over in idle");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_stack_cnt) <= STACK_DEPTH)
        else $error("held stack count beyond depth");

    a_finished_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.opcode == OP_FINISHED) |=> (r_state == S_IDLE))
        else $error("voice finished event did not complete at once");

    a_compact_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CMP) |-> (r_wr <= r_rd && r_rd <= r_stack_cnt))
        else $error("stack compaction pointers out of order");

endmodule
`default_nettype wire

// ----- bench/tb_synth_voice_allocator.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_synth_voice_allocator;
    import sva_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int SETTLE = 3 * 256 + 3 * VOICES + 20;
    localparam int HOLD_CYCLES = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    synth_voice_allocator uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // allocator mirror
    logic mdl_mono;
    logic [4:0] mdl_limit;
    logic mdl_dual;
    logic snd [VOICES];
    logic hld [VOICES];
    t_key vkey [VOICES];
    logic [31:0] vage [VOICES];
    logic [31:0] age_ctr;
    t_key held_stack [STACK_DEPTH];
    int held_cnt;

    t_in_item pending_events[$];
    t_out_item expected_cmds[$];
    int n_cmds;
    int errors = 0;
    int cycle = 0;
    bit idle_free = 1'b0;
    bit hold_rx = 1'b0;
    bit hold_started = 1'b0;
    int hold_left = 0;

    function automatic void push_cmd(int v, logic act, t_key k);
        t_out_item c;
        if (n_cmds >= 16) return;
        c.voice_index = v[3:0];
        c.action = act;
        c.key_channel = k[10:7];
        c.key_note = k[6:0];
        c.last = 1'b0;
        expected_cmds = {expected_cmds, c};
        n_cmds++;
    endfunction

    function automatic void queue_event(t_in_item e);
        pending_events = {pending_events, e};
    endfunction

    function automatic void play(int v, t_key k);
        snd[v] = 1'b1;
        hld[v] = 1'b1;
        vkey[v] = k;
        vage[v] = age_ctr;
        age_ctr = age_ctr + 1;
        push_cmd(v, ACT_TRIG, k);
    endfunction

    function automatic void silence(int v);
        hld[v] = 1'b0;
        push_cmd(v, ACT_REL, vkey[v]);
    endfunction

    function automatic int pick_voice();
        int lim;
        int best;
        logic [31:0] span;
        lim = (mdl_limit > VOICES) ? VOICES : mdl_limit;
        if (mdl_dual) lim = lim / 2;
        for (int i = 0; i < lim; i++) if (!snd[i]) return i;
        best = 0;
        span = age_ctr - vage[0];
        for (int i = 1; i < lim; i++)
            if (age_ctr - vage[i] > span) begin
                span = age_ctr - vage[i];
                best = i;
            end
        return best;
    endfunction

    function automatic void apply_event(t_in_item e);
        t_key k;
        bit done;
        int w;
        k = {e.channel, e.note};
        n_cmds = 0;
        case (e.opcode)
            OP_NOTE_ON: begin
                if (mdl_mono) begin
                    if (held_cnt < STACK_DEPTH) begin
                        held_stack[held_cnt] = k;
                        held_cnt++;
                    end
                    play(0, k);
                end else begin
                    done = 1'b0;
                    for (int v = 0; v < VOICES && !done; v++)
                        if (hld[v] && vkey[v] == k) begin
                            play(v, k);
                            done = 1'b1;
                        end
                    if (!done) play(pick_voice(), k);
                end
            end
            OP_NOTE_OFF: begin
                if (mdl_mono) begin
                    w = 0;
                    for (int r = 0; r < held_cnt; r++)
                        if (held_stack[r] != k) begin
                            held_stack[w] = held_stack[r];
                            w++;
                        end
                    held_cnt = w;
                    if (hld[0] && vkey[0] == k) begin
                        if (held_cnt > 0) play(0, held_stack[held_cnt-1]);
                        else silence(0);
                    end
                end else begin
                    for (int v = 0; v < VOICES; v++)
                        if (hld[v] && vkey[v] == k) silence(v);
                end
            end
            OP_ALL_OFF: begin
                for (int v = 0; v < VOICES; v++) if (snd[v]) silence(v);
                held_cnt = 0;
            end
            default: begin
                if (e.voice < VOICES) begin
                    snd[e.voice] = 1'b0;
                    hld[e.voice] = 1'b0;
                end
            end
        endcase
        if (n_cmds > 0) expected_cmds[expected_cmds.size()-1].last = 1'b1;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) apply_event(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_events.size() > 0 && (idle_free || $urandom_range(99) >= 35)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_events.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_out_item exp_c;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_cmds.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected command %p", o_out_data);
                end else begin
                    exp_c = expected_cmds.pop_front();
                    if (exp_c !== o_out_data) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p actual %p", exp_c, o_out_data);
                    end
                end
            end
            if (hold_rx && !hold_started) begin
                hold_started <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !idle_free && $urandom_range(99) < 35;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("tb_synth_voice_allocator failed");
            $finish;
        end
    end

    task automatic wait_clk(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_events.size() > 0 || i_in_valid || expected_cmds.size() > 0)
            @(posedge i_clk);
        wait_clk(SETTLE);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MONO: mdl_mono = val[0];
            REG_LIMIT: mdl_limit = val[4:0];
            default: mdl_dual = val[0];
        endcase
    endtask

    function automatic t_in_item mk(logic [1:0] op, logic [3:0] ch, logic [6:0] nt,
                                    logic [3:0] vc);
        t_in_item e;
        e.opcode = op;
        e.channel = ch;
        e.note = nt;
        e.voice = vc;
        return e;
    endfunction

    // keys from a small pool so note offs and retriggers hit
    function automatic t_in_item rand_event(int pool);
        t_in_item e;
        int r;
        r = $urandom_range(99);
        e.channel = 4'($urandom_range(pool));
        e.note = (e.channel == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(pool) * 37);
        if (r < 10) e.channel = 4'($urandom_range(15));
        e.voice = 4'($urandom_range(15));
        if (r < 45) e.opcode = OP_NOTE_ON;
        else if (r < 75) e.opcode = OP_NOTE_OFF;
        else if (r < 80) e.opcode = OP_ALL_OFF;
        else e.opcode = OP_FINISHED;
        return e;
    endfunction

    task automatic random_phase(int n, int pool);
        repeat (n) queue_event(rand_event(pool));
        drain();
    endtask

    initial begin
        mdl_mono = 1'b0;
        mdl_limit = 5'd16;
        mdl_dual = 1'b0;
        for (int i = 0; i < VOICES; i++) begin
            snd[i] = 1'b0;
            hld[i] = 1'b0;
            vkey[i] = '0;
            vage[i] = '0;
        end
        age_ctr = '0;
        held_cnt = 0;
        wait_clk(2);
        i_rst_n <= 1'b1;

        // directed: extremes, retrigger, steal, all off, finished
        queue_event(mk(OP_NOTE_ON, 4'd0, 7'd0, 4'd0));
        queue_event(mk(OP_NOTE_ON, 4'd15, 7'd127, 4'd15));
        queue_event(mk(OP_NOTE_ON, 4'd15, 7'd127, 4'd0));
        for (int i = 0; i < 16; i++)
            queue_event(mk(OP_NOTE_ON, 4'(i), 7'(i + 40), 4'd0));
        queue_event(mk(OP_NOTE_OFF, 4'd15, 7'd127, 4'd0));
        queue_event(mk(OP_FINISHED, 4'd0, 7'd0, 4'd3));
        queue_event(mk(OP_ALL_OFF, 4'd0, 7'd0, 4'd0));
        queue_event(mk(OP_FINISHED, 4'd5, 7'd85, 4'd15));
        drain();

        // long receiver hold so the block backs up
        hold_rx = 1'b1;
        repeat (30) queue_event(mk(OP_NOTE_ON, 4'($urandom_range(15)),
                                   7'($urandom_range(127)), 4'd0));
        wait (hold_started);
        while (hold_left > 0) @(posedge i_clk);
        drain();

        reg_write(REG_LIMIT, 32'd2);
        random_phase(20, 3);
        reg_write(REG_DUAL, 32'd1);
        reg_write(REG_LIMIT, 32'd5);
        random_phase(20, 3);
        reg_write(REG_LIMIT, 32'd16);
        random_phase(20, 5);
        reg_write(REG_DUAL, 32'd0);
        idle_free = 1'b1;
        random_phase(30, 6);
        idle_free = 1'b0;
        reg_write(REG_MONO, 32'd1);
        queue_event(mk(OP_NOTE_ON, 4'd1, 7'd10, 4'd0));
        queue_event(mk(OP_NOTE_ON, 4'd1, 7'd11, 4'd0));
        queue_event(mk(OP_NOTE_ON, 4'd1, 7'd10, 4'd0));
        queue_event(mk(OP_NOTE_OFF, 4'd1, 7'd10, 4'd0));
        queue_event(mk(OP_NOTE_OFF, 4'd1, 7'd11, 4'd0));
        drain();
        random_phase(20, 3);
        // fill the held stack past its depth, then unwind
        for (int i = 0; i < STACK_DEPTH + 4; i++)
            queue_event(mk(OP_NOTE_ON, 4'(i % 3), 7'(i % 5), 4'd0));
        queue_event(mk(OP_NOTE_OFF, 4'd0, 7'd0, 4'd0));
        queue_event(mk(OP_NOTE_OFF, 4'd2, 7'd3, 4'd0));
        queue_event(mk(OP_ALL_OFF, 4'd0, 7'd0, 4'd0));
        drain();
        reg_write(REG_MONO, 32'd0);
        reg_write(REG_LIMIT, 32'd31);
        random_phase(20, 4);
        reg_write(REG_LIMIT, 32'd0);
        random_phase(10, 2);

        if (errors == 0) begin
            $display("tb_synth_voice_allocator passed");
        end else begin
            $display("tb_synth_voice_allocator failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
